// ----- hdl/bt2dm_pkg.sv -----
package bt2dm_pkg;

  typedef struct packed {
    logic [15:0] s0;
    logic [16:0] mix_fraction;
    logic [15:0] rate_a;
    logic [15:0] rate_b;
  } in_item_t;

  typedef struct packed {
    logic [31:0] signal;
    logic [2:0]  echo_index;
    logic        last_echo;
  } out_item_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] s0;
    logic [16:0] mix;
    logic [2:0]  idx;
    logic        last;
    logic [32:0] pa;
    logic [32:0] pb;
    logic        za;
    logic        zb;
    logic [23:0] fa;
    logic [23:0] fb;
  } step_t;

  localparam logic [3:0] REG_TWO_COMP    = 4'd0;
  localparam logic [3:0] REG_FREE_RATES  = 4'd1;
  localparam logic [3:0] REG_ECHO_COUNT  = 4'd2;
  localparam logic [3:0] REG_ECHO_TIME0  = 4'd3;

  localparam logic [15:0] RATE_TWO_A = 16'd2944;
  localparam logic [15:0] RATE_TWO_B = 16'd1024;
  localparam logic [15:0] RATE_ONE   = 16'd3200;
  localparam logic [16:0] ONE_Q16    = 17'd65536;

  typedef logic [31:0] fact_tab_t [25];
  typedef logic [32:0] ipow_tab_t [16];

  function automatic logic [63:0] exp_neg_pow2(input int k);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 40;
    sum  = term;
    for (int n = 1; n <= 30; n++) begin
      term = (term >> k) / 64'(n);
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum + 64'd128) >> 8;
  endfunction

  function automatic logic [32:0] mul_q32(input logic [32:0] p, input logic [31:0] f);
    logic [63:0] prod;
    prod = 64'(p[31:0]) * 64'(f) + 64'h8000_0000;
    if (p[32]) begin
      return {1'b0, f};
    end
    return {1'b0, prod[63:32]};
  endfunction

  function automatic fact_tab_t fact_table();
    fact_tab_t t;
    for (int k = 0; k < 25; k++) begin
      t[k] = 32'(exp_neg_pow2(k));
    end
    return t;
  endfunction

  function automatic ipow_tab_t ipow_table();
    ipow_tab_t t;
    logic [31:0] e1;
    e1 = 32'(exp_neg_pow2(0));
    t[0] = 33'h1_0000_0000;
    for (int i = 1; i < 16; i++) begin
      t[i] = mul_q32(t[i-1], e1);
    end
    return t;
  endfunction

  localparam fact_tab_t FACT = fact_table();
  localparam ipow_tab_t IPOW = ipow_table();

endpackage

// ----- hdl/bt2dm_exp_step.sv -----
module bt2dm_exp_step #(
  parameter int K = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  bt2dm_pkg::step_t d,
  output bt2dm_pkg::step_t q
);
  import bt2dm_pkg::*;

  localparam int BIT = 24 - K;
  localparam logic [31:0] F = FACT[K];

  step_t q_r;
  step_t q_nxt;

  always_comb begin
    q_nxt = d;
    if (d.fa[BIT]) begin
      q_nxt.pa = mul_q32(d.pa, F);
    end
    if (d.fb[BIT]) begin
      q_nxt.pb = mul_q32(d.pb, F);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ----- hdl/biexponential_t2_decay_model.sv -----
// Bi-exponential T2 decay model. Each accepted request (s0, mix fraction,
// two Q8.8 decay rates) yields one Q16.16 signal per configured echo time,
// in echo order, the last one flagged. The echo issuer sends one echo a
// cycle, unless the output stalls, into a 29-stage pipeline (rate
// products, integer-part table, 24 multiply stages for the fraction bits
// of the exponent, rounding, mixing, scaling). A new request is taken
// when idle or as the last echo of the previous one issues. A stall at
// the output freezes the whole pipeline. The user must write configuration
// via cfg_* (always ready) only while no request is in flight (not enforced).
module biexponential_t2_decay_model #(
  parameter int MAX_ECHOES = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bt2dm_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bt2dm_pkg::out_item_t  out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import bt2dm_pkg::*;

  localparam int IDX_W = (MAX_ECHOES > 1) ? $clog2(MAX_ECHOES) : 1;

  logic              two_comp_r;
  logic              free_rates_r;
  logic [2:0]        echo_count_r;
  logic [15:0]       echo_time_r [MAX_ECHOES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_comp_r   <= 1'b0;
      free_rates_r <= 1'b0;
      echo_count_r <= 3'd1;
      for (int i = 0; i < MAX_ECHOES; i++) begin
        echo_time_r[i] <= 16'd0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == REG_TWO_COMP) begin
        two_comp_r <= cfg_data[0];
      end
      if (cfg_index == REG_FREE_RATES) begin
        free_rates_r <= cfg_data[0];
      end
      if (cfg_index == REG_ECHO_COUNT) begin
        echo_count_r <= cfg_data[2:0];
      end
      for (int i = 0; i < MAX_ECHOES; i++) begin
        if (cfg_index == 4'(REG_ECHO_TIME0 + 4'(i))) begin
          echo_time_r[i] <= cfg_data;
        end
      end
    end
  end

  // echo issuer
  logic              adv;
  logic              busy_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  lim_r;
  logic [15:0]       s0_r;
  logic [16:0]       mix_r;
  logic [15:0]       ra_r;
  logic [15:0]       rb_r;
  logic              issue;
  logic              last_issue;
  logic              acc;
  logic [2:0]        cnt_sat;
  logic [16:0]       mix_sel;
  logic [15:0]       ra_sel;
  logic [15:0]       rb_sel;

  logic              out_vld_r;

  assign adv        = !(out_vld_r && out_stall);
  assign issue      = busy_r && adv;
  assign last_issue = issue && (cnt_r == lim_r);
  assign in_stall   = busy_r && !last_issue;
  assign acc        = in_valid && !in_stall;

  always_comb begin
    cnt_sat = (echo_count_r > 3'(MAX_ECHOES)) ? 3'(MAX_ECHOES) : echo_count_r;
    mix_sel = (in_item.mix_fraction > ONE_Q16) ? ONE_Q16 : in_item.mix_fraction;
    ra_sel  = in_item.rate_a;
    rb_sel  = in_item.rate_b;
    if (two_comp_r) begin
      if (!free_rates_r) begin
        ra_sel = RATE_TWO_A;
        rb_sel = RATE_TWO_B;
      end
    end else begin
      mix_sel = 17'd0;
      rb_sel  = 16'd0;
      if (!free_rates_r) begin
        ra_sel = RATE_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (acc && cnt_sat != 3'd0) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (last_issue) begin
      busy_r <= 1'b0;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s0_r  <= in_item.s0;
      mix_r <= mix_sel;
      ra_r  <= ra_sel;
      rb_r  <= rb_sel;
      lim_r <= IDX_W'(cnt_sat - 3'd1);
    end
  end

  // stage A: exponent products
  logic              a_vld_r;
  logic [15:0]       a_s0_r;
  logic [16:0]       a_mix_r;
  logic [2:0]        a_idx_r;
  logic              a_last_r;
  logic [31:0]       a_xa_r;
  logic [31:0]       a_xb_r;
  logic [15:0]       te;

  assign te = echo_time_r[cnt_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_s0_r   <= s0_r;
      a_mix_r  <= mix_r;
      a_idx_r  <= 3'(cnt_r);
      a_last_r <= (cnt_r == lim_r);
      a_xa_r   <= 32'(ra_r) * 32'(te);
      a_xb_r   <= 32'(rb_r) * 32'(te);
    end
  end

  // stage B: integer part from table
  step_t st [25];
  step_t b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.vld <= 1'b0;
    end else if (adv) begin
      b_r.vld  <= a_vld_r;
      b_r.s0   <= a_s0_r;
      b_r.mix  <= a_mix_r;
      b_r.idx  <= a_idx_r;
      b_r.last <= a_last_r;
      b_r.za   <= |a_xa_r[31:28];
      b_r.zb   <= |a_xb_r[31:28];
      b_r.pa   <= IPOW[a_xa_r[27:24]];
      b_r.pb   <= IPOW[a_xb_r[27:24]];
      b_r.fa   <= a_xa_r[23:0];
      b_r.fb   <= a_xb_r[23:0];
    end
  end

  assign st[0] = b_r;

  for (genvar j = 0; j < 24; j++) begin : g_step
    bt2dm_exp_step #(.K(j + 1)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d     (st[j]),
      .q     (st[j+1])
    );
  end

  // round to Q1.16
  logic              r_vld_r;
  logic [15:0]       r_s0_r;
  logic [16:0]       r_mix_r;
  logic [2:0]        r_idx_r;
  logic              r_last_r;
  logic [16:0]       r_ea_r;
  logic [16:0]       r_eb_r;
  logic [32:0]       ra_rnd;
  logic [32:0]       rb_rnd;

  assign ra_rnd = st[24].pa + 33'd32768;
  assign rb_rnd = st[24].pb + 33'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else if (adv) begin
      r_vld_r <= st[24].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_s0_r   <= st[24].s0;
      r_mix_r  <= st[24].mix;
      r_idx_r  <= st[24].idx;
      r_last_r <= st[24].last;
      r_ea_r   <= st[24].za ? 17'd0 : ra_rnd[32:16];
      r_eb_r   <= st[24].zb ? 17'd0 : rb_rnd[32:16];
    end
  end

  // mix
  logic              m_vld_r;
  logic [15:0]       m_s0_r;
  logic [2:0]        m_idx_r;
  logic              m_last_r;
  logic [32:0]       m_mixed_r;
  logic [16:0]       wa;

  assign wa = ONE_Q16 - r_mix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_s0_r    <= r_s0_r;
      m_idx_r   <= r_idx_r;
      m_last_r  <= r_last_r;
      m_mixed_r <= 33'(34'(wa) * 34'(r_ea_r) + 34'(r_mix_r) * 34'(r_eb_r));
    end
  end

  // scale and output
  logic [31:0]       out_sig_r;
  logic [2:0]        out_idx_r;
  logic              out_last_r;
  logic [48:0]       scaled;

  assign scaled = 49'(m_s0_r) * 49'(m_mixed_r) + 49'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sig_r  <= scaled[47:16];
      out_idx_r  <= m_idx_r;
      out_last_r <= m_last_r;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_item.signal     = out_sig_r;
  assign out_item.echo_index = out_idx_r;
  assign out_item.last_echo  = out_last_r;

endmodule
